@@ design/rci_pkg.sv @@
// ----------------------------------------------------------------------------
// rci_pkg: ray / circle intersection shared definitions
// Coordinate format, derived datapath widths, register map and payload types.
// ----------------------------------------------------------------------------
package rci_pkg;

	localparam int COORD_W = 32;                 // coordinate width
	localparam int FRAC_W  = 16;                 // fraction bits
	localparam int DATA_W  = 32;                 // config bus width
	localparam int ADDR_W  = 4;                  // config byte address width
	localparam int IDX_W   = ADDR_W - 2;

	localparam int PW   = COORD_W + 1;           // O - C
	localparam int AW   = 2 * COORD_W;           // a = D.D
	localparam int HW   = 2 * COORD_W + 2;       // h = D.P, signed
	localparam int HM   = HW - 1;                // |h|
	localparam int CW   = 2 * COORD_W + 3;       // c = P.P - r^2, signed
	localparam int CM   = CW - 1;                // |c|
	localparam int DM   = HM + HM;               // h^2 and a*|c|
	localparam int DSW  = DM + 1;                // discriminant, signed
	localparam int RADW = DM + 2 * FRAC_W;       // radicand of the root
	localparam int RTW  = RADW / 2;              // root width
	localparam int NUMW = RTW + 1;               // quotient numerator

	localparam int MUL_LAT = 3;                  // latency of rci_mul

	localparam logic [IDX_W-1:0] REG_CENTER_X = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_CENTER_Y = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_RADIUS   = IDX_W'(2);

	typedef struct packed {
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_y;
		logic signed [COORD_W-1:0] dir_x;
		logic signed [COORD_W-1:0] dir_y;
	} ray_t;

	typedef struct packed {
		logic               hit;
		logic [COORD_W-1:0] distance;
		logic               far_root;
		logic               saturated;
	} result_t;

endpackage

@@ design/ray_circle_intersection_unit.sv @@
// ----------------------------------------------------------------------------
// ray_circle_intersection_unit: 2D ray against a configured circle
// Solves a t^2 + 2h t + c = 0 in integer arithmetic and reports the nearest positive root.
// ----------------------------------------------------------------------------
//  channel  signals                            transaction
//  ray      start, busy, ray                   start high while busy low
//  result   result_valid, result               one cycle strobe, no backpressure
//  config   psel penable pwrite paddr pwdata   APB write, pready tied high
//           prdata
//
//  One ray per cycle. The pipeline length is set by the square root,
//  one bit per stage, and the divider, one quotient bit per stage.
//  busy stays low; the pipeline never stalls.
//  Reset clears the configuration registers and all valid bits.
// ----------------------------------------------------------------------------
module ray_circle_intersection_unit
	import rci_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  ray_t              ray,
	output logic              result_valid,
	output result_t           result
);
	localparam int PIPE_LAT = 7 + 2 * MUL_LAT + RTW + COORD_W;
	localparam int S2W      = HM + AW + 5;
	localparam int SQW      = RTW + AW + 4;

	// configuration registers
	logic [COORD_W-1:0] cx_q, cy_q;
	logic [COORD_W-2:0] r_q;
	logic [IDX_W-1:0]   reg_idx;
	logic               wr_en;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign busy    = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			r_q  <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CENTER_X: cx_q <= pwdata[COORD_W-1:0];
				REG_CENTER_Y: cy_q <= pwdata[COORD_W-1:0];
				REG_RADIUS:   r_q  <= pwdata[COORD_W-2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CENTER_X: prdata = DATA_W'(cx_q);
			REG_CENTER_Y: prdata = DATA_W'(cy_q);
			REG_RADIUS:   prdata = DATA_W'(r_q);
			default:      prdata = '0;
		endcase
	end

	// stage 1: P = O - C
	logic               vld_s1;
	logic [PW-1:0]      px_s1, py_s1;
	logic [COORD_W-1:0] dx_s1, dy_s1;

	always_ff @(posedge clk) begin
		px_s1 <= {ray.origin_x[COORD_W-1], ray.origin_x} - {cx_q[COORD_W-1], cx_q};
		py_s1 <= {ray.origin_y[COORD_W-1], ray.origin_y} - {cy_q[COORD_W-1], cy_q};
		dx_s1 <= ray.dir_x;
		dy_s1 <= ray.dir_y;
	end

	// stage 2: magnitudes and product signs
	logic               vld_s2;
	logic [PW-1:0]      mpx_s2, mpy_s2;
	logic [COORD_W-1:0] mdx_s2, mdy_s2;
	logic [1:0]         sgn_s2;

	always_ff @(posedge clk) begin
		mpx_s2 <= px_s1[PW-1] ? -px_s1 : px_s1;
		mpy_s2 <= py_s1[PW-1] ? -py_s1 : py_s1;
		mdx_s2 <= dx_s1[COORD_W-1] ? -dx_s1 : dx_s1;
		mdy_s2 <= dy_s1[COORD_W-1] ? -dy_s1 : dy_s1;
		sgn_s2 <= {dx_s1[COORD_W-1] ^ px_s1[PW-1], dy_s1[COORD_W-1] ^ py_s1[PW-1]};
	end

	// first multiply bank
	logic [AW-1:0]           p_dxx, p_dyy;
	logic [COORD_W+PW-1:0]   p_dxpx, p_dypy;
	logic [2*PW-1:0]         p_pxx, p_pyy;
	logic [2*COORD_W-3:0]    p_rr;
	logic [MUL_LAT-1:0]      vld_m1;
	logic [1:0]              sgn_m1 [MUL_LAT];

	rci_mul #(.AW(COORD_W), .BW(COORD_W)) u_dxx (.clk, .a(mdx_s2), .b(mdx_s2), .p(p_dxx));
	rci_mul #(.AW(COORD_W), .BW(COORD_W)) u_dyy (.clk, .a(mdy_s2), .b(mdy_s2), .p(p_dyy));
	rci_mul #(.AW(COORD_W), .BW(PW)) u_dxpx (.clk, .a(mdx_s2), .b(mpx_s2), .p(p_dxpx));
	rci_mul #(.AW(COORD_W), .BW(PW)) u_dypy (.clk, .a(mdy_s2), .b(mpy_s2), .p(p_dypy));
	rci_mul #(.AW(PW), .BW(PW)) u_pxx (.clk, .a(mpx_s2), .b(mpx_s2), .p(p_pxx));
	rci_mul #(.AW(PW), .BW(PW)) u_pyy (.clk, .a(mpy_s2), .b(mpy_s2), .p(p_pyy));
	rci_mul #(.AW(COORD_W-1), .BW(COORD_W-1)) u_rr (.clk, .a(r_q), .b(r_q), .p(p_rr));

	always_ff @(posedge clk) begin
		sgn_m1[0] <= sgn_s2;
		for (int i = 1; i < MUL_LAT; i++) begin
			sgn_m1[i] <= sgn_m1[i-1];
		end
	end

	// stage 3: a, h, c
	logic          vld_s3;
	logic [AW-1:0] a_s3;
	logic [HW-1:0] h_s3;
	logic [CW-1:0] c_s3;
	logic [HW-1:0] hx_c, hy_c;

	always_comb begin
		hx_c = sgn_m1[MUL_LAT-1][1] ? -HW'(p_dxpx) : HW'(p_dxpx);
		hy_c = sgn_m1[MUL_LAT-1][0] ? -HW'(p_dypy) : HW'(p_dypy);
	end

	always_ff @(posedge clk) begin
		a_s3 <= p_dxx + p_dyy;
		h_s3 <= hx_c + hy_c;
		c_s3 <= CW'(p_pxx) + CW'(p_pyy) - CW'(p_rr);
	end

	// stage 4: magnitudes and root choice
	logic          vld_s4;
	logic [AW-1:0] a_s4;
	logic [HM-1:0] mh_s4;
	logic [CM-1:0] mc_s4;
	logic          cneg_s4, near_s4, far_s4, hneg_s4, anz_s4;
	logic          hneg_c, cneg_c, cpos_c, near_c;

	always_comb begin
		hneg_c = h_s3[HW-1];
		cneg_c = c_s3[CW-1];
		cpos_c = !cneg_c && (c_s3 != '0);
		near_c = hneg_c && cpos_c;
	end

	always_ff @(posedge clk) begin
		a_s4    <= a_s3;
		mh_s4   <= hneg_c ? HM'(-h_s3) : HM'(h_s3);
		mc_s4   <= cneg_c ? CM'(-c_s3) : CM'(c_s3);
		cneg_s4 <= cneg_c;
		near_s4 <= near_c;
		far_s4  <= !near_c && (hneg_c || cneg_c);
		hneg_s4 <= hneg_c;
		anz_s4  <= a_s3 != '0;
	end

	// second multiply bank
	logic [DM-1:0]      p_hh, p_ac;
	logic [MUL_LAT-1:0] vld_m2;
	logic [S2W-1:0]     side_m2 [MUL_LAT];

	rci_mul #(.AW(HM), .BW(HM)) u_hh (.clk, .a(mh_s4), .b(mh_s4), .p(p_hh));
	rci_mul #(.AW(AW), .BW(CM)) u_ac (.clk, .a(a_s4), .b(mc_s4), .p(p_ac));

	always_ff @(posedge clk) begin
		side_m2[0] <= {mh_s4, a_s4, cneg_s4, near_s4, far_s4, hneg_s4, anz_s4};
		for (int i = 1; i < MUL_LAT; i++) begin
			side_m2[i] <= side_m2[i-1];
		end
	end

	// stage 5: discriminant
	logic [HM-1:0]   m2_mh;
	logic [AW-1:0]   m2_a;
	logic            m2_cneg, m2_near, m2_far, m2_hneg, m2_anz;
	logic [DSW-1:0]  disc_c;
	logic            vld_s5;
	logic [RADW-1:0] rad_s5;
	logic [SQW-1:0]  side_s5;

	always_comb begin
		{m2_mh, m2_a, m2_cneg, m2_near, m2_far, m2_hneg, m2_anz} = side_m2[MUL_LAT-1];
		// c < 0 makes -a*c positive
		disc_c = m2_cneg ? DSW'(p_hh) + DSW'(p_ac) : DSW'(p_hh) - DSW'(p_ac);
	end

	always_ff @(posedge clk) begin
		rad_s5  <= {disc_c[DM-1:0], {(2*FRAC_W){1'b0}}};
		side_s5 <= {m2_mh, {FRAC_W{1'b0}}, m2_a, m2_near, m2_far, m2_hneg,
			m2_anz && !disc_c[DSW-1] && (m2_near || m2_far)};
	end

	// square root of disc * 2^(2F)
	logic           sq_vld;
	logic [RTW-1:0] sq_root;
	logic [SQW-1:0] sq_side;

	rci_sqrt #(.NW(RADW), .SW(SQW)) u_sqrt (
		.clk,
		.arst_n,
		.in_vld  (vld_s5),
		.rad     (rad_s5),
		.in_side (side_s5),
		.out_vld (sq_vld),
		.root    (sq_root),
		.out_side(sq_side)
	);

	// stage 6: numerator and saturation
	logic [RTW-1:0]  sq_hs;
	logic [AW-1:0]   sq_a;
	logic            sq_near, sq_far, sq_hneg, sq_hit;
	logic [NUMW-1:0] num_c;
	logic            vld_s6;
	logic [NUMW-1:0] num_s6;
	logic [AW-1:0]   a_s6;
	logic [2:0]      side_s6;

	always_comb begin
		{sq_hs, sq_a, sq_near, sq_far, sq_hneg, sq_hit} = sq_side;
		if (sq_near) begin
			num_c = (sq_hs > sq_root) ? NUMW'(sq_hs - sq_root) : '0;
		end else if (sq_hneg) begin
			num_c = NUMW'(sq_hs) + NUMW'(sq_root);
		end else begin
			num_c = (sq_root > sq_hs) ? NUMW'(sq_root - sq_hs) : '0;
		end
	end

	always_ff @(posedge clk) begin
		num_s6  <= num_c;
		a_s6    <= sq_a;
		// quotient reaches 2^COORD_W exactly when num >= a * 2^COORD_W
		side_s6 <= {sq_hit, sq_far, (num_c >> COORD_W) >= NUMW'(sq_a)};
	end

	// divide by a
	logic               dv_vld;
	logic [COORD_W-1:0] dv_quo;
	logic [2:0]         dv_side;
	logic               dv_hit, dv_far, dv_sat;

	rci_div #(.NW(NUMW), .DW(AW), .QW(COORD_W), .SW(3)) u_div (
		.clk,
		.arst_n,
		.in_vld  (vld_s6),
		.num     (num_s6),
		.den     (a_s6),
		.in_side (side_s6),
		.out_vld (dv_vld),
		.quo     (dv_quo),
		.out_side(dv_side)
	);

	assign {dv_hit, dv_far, dv_sat} = dv_side;

	// stage 7: result
	logic    vld_s7;
	result_t res_s7;

	always_ff @(posedge clk) begin
		res_s7.hit       <= dv_hit;
		res_s7.distance  <= !dv_hit ? '0 : (dv_sat ? '1 : dv_quo);
		res_s7.far_root  <= dv_hit && dv_far;
		res_s7.saturated <= dv_hit && dv_sat;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_m1 <= '0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_m2 <= '0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_m1 <= {vld_m1[MUL_LAT-2:0], vld_s2};
			vld_s3 <= vld_m1[MUL_LAT-1];
			vld_s4 <= vld_s3;
			vld_m2 <= {vld_m2[MUL_LAT-2:0], vld_s4};
			vld_s5 <= vld_m2[MUL_LAT-1];
			vld_s6 <= sq_vld;
			vld_s7 <= dv_vld;
		end
	end

	assign result_valid = vld_s7;
	assign result       = res_s7;

	// checks
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##PIPE_LAT result_valid)
		else $error("result transaction missing after pipeline latency");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.hit |->
			result.distance == '0 && !result.far_root && !result.saturated)
		else $error("miss carries nonzero fields");

	a_sat_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.saturated |-> &result.distance)
		else $error("saturated distance not full scale");

endmodule

@@ design/rci_mul.sv @@
// ----------------------------------------------------------------------------
// rci_mul: pipelined unsigned multiplier
// 32x32 partial products, row sums, final sum; three register stages.
// ----------------------------------------------------------------------------
module rci_mul #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic          clk,
	input  logic [AW-1:0] a,
	input  logic [BW-1:0] b,
	output logic [AW+BW-1:0] p
);
	localparam int CHK = 32;
	localparam int NA  = (AW + CHK - 1) / CHK;
	localparam int NB  = (BW + CHK - 1) / CHK;
	localparam int PWD = AW + BW;

	logic [NA*CHK-1:0] a_ext;
	logic [NB*CHK-1:0] b_ext;
	logic [2*CHK-1:0]  pp_s1 [NA][NB];
	logic [PWD-1:0]    row_c [NA];
	logic [PWD-1:0]    row_s2 [NA];
	logic [PWD-1:0]    sum_c;
	logic [PWD-1:0]    p_s3;

	assign a_ext = (NA*CHK)'(a);
	assign b_ext = (NB*CHK)'(b);

	always_ff @(posedge clk) begin
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				pp_s1[i][j] <= a_ext[i*CHK +: CHK] * b_ext[j*CHK +: CHK];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row_c[i] = row_c[i] + (PWD'(pp_s1[i][j]) << (j * CHK));
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NA; i++) begin
			row_s2[i] <= row_c[i];
		end
	end

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < NA; i++) begin
			sum_c = sum_c + (row_s2[i] << (i * CHK));
		end
	end

	always_ff @(posedge clk) begin
		p_s3 <= sum_c;
	end

	assign p = p_s3;

endmodule

@@ design/rci_sqrt.sv @@
// ----------------------------------------------------------------------------
// rci_sqrt: pipelined integer square root
// One root bit per stage, floor(sqrt(rad)); sideband travels with the data.
// ----------------------------------------------------------------------------
module rci_sqrt #(
	parameter int NW = 162,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  logic [NW-1:0]   rad,
	input  logic [SW-1:0]   in_side,
	output logic            out_vld,
	output logic [NW/2-1:0] root,
	output logic [SW-1:0]   out_side
);
	localparam int RW = NW / 2;

	logic          vld_s  [1:RW];
	logic [NW-1:0] rad_s  [1:RW];
	logic [RW+1:0] rem_s  [1:RW];
	logic [RW-1:0] root_s [1:RW];
	logic [SW-1:0] side_s [1:RW];

	for (genvar k = 1; k <= RW; k++) begin : g_step
		logic          v_in;
		logic [NW-1:0] rad_in;
		logic [RW+1:0] rem_in;
		logic [RW-1:0] root_in;
		logic [SW-1:0] side_in;
		logic [RW+1:0] cur;
		logic [RW+1:0] trial;
		logic          fit;

		if (k == 1) begin : g_head
			assign v_in    = in_vld;
			assign rad_in  = rad;
			assign rem_in  = '0;
			assign root_in = '0;
			assign side_in = in_side;
		end else begin : g_body
			assign v_in    = vld_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign side_in = side_s[k-1];
		end

		// remainder stays below 2^k here, so its low RW bits carry it
		assign cur   = {rem_in[RW-1:0], rad_in[NW-1 -: 2]};
		assign trial = {root_in, 2'b01};
		assign fit   = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rad_s[k]  <= rad_in << 2;
			rem_s[k]  <= fit ? cur - trial : cur;
			root_s[k] <= {root_in[RW-2:0], fit};
			side_s[k] <= side_in;
		end
	end

	assign out_vld  = vld_s[RW];
	assign root     = root_s[RW];
	assign out_side = side_s[RW];

endmodule

@@ design/rci_div.sv @@
// ----------------------------------------------------------------------------
// rci_div: pipelined restoring divider
// One quotient bit per stage; valid when num / den < 2^QW.
// ----------------------------------------------------------------------------
module rci_div #(
	parameter int NW = 82,
	parameter int DW = 64,
	parameter int QW = 32,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] in_side,
	output logic          out_vld,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] out_side
);
	logic          vld_s  [1:QW];
	logic [DW-1:0] rem_s  [1:QW];
	logic [QW-1:0] lo_s   [1:QW];
	logic [QW-1:0] q_s    [1:QW];
	logic [DW-1:0] den_s  [1:QW];
	logic [SW-1:0] side_s [1:QW];

	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic          v_in;
		logic [DW-1:0] rem_in;
		logic [QW-1:0] lo_in;
		logic [QW-1:0] q_in;
		logic [DW-1:0] den_in;
		logic [SW-1:0] side_in;
		logic [DW:0]   cur;
		logic          fit;

		if (k == 1) begin : g_head
			assign v_in    = in_vld;
			assign rem_in  = DW'(num >> QW);
			assign lo_in   = num[QW-1:0];
			assign q_in    = '0;
			assign den_in  = den;
			assign side_in = in_side;
		end else begin : g_body
			assign v_in    = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign lo_in   = lo_s[k-1];
			assign q_in    = q_s[k-1];
			assign den_in  = den_s[k-1];
			assign side_in = side_s[k-1];
		end

		assign cur = {rem_in, lo_in[QW-1]};
		assign fit = cur >= {1'b0, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= DW'(fit ? cur - {1'b0, den_in} : cur);
			lo_s[k]   <= lo_in << 1;
			q_s[k]    <= {q_in[QW-2:0], fit};
			den_s[k]  <= den_in;
			side_s[k] <= side_in;
		end
	end

	assign out_vld  = vld_s[QW];
	assign quo      = q_s[QW];
	assign out_side = side_s[QW];

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: ray / circle intersection unit testbench
// Drives rays through the command port and circle settings through APB.
// Every result is checked against a wide-integer root solver kept here.
// ----------------------------------------------------------------------------
module tb_top;
	import rci_pkg::*;

	typedef logic signed [255:0] wide_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              start;
	logic              busy;
	ray_t              ray;
	logic              result_valid;
	result_t           result;

	// circle as currently programmed
	logic signed [COORD_W-1:0] circ_cx;
	logic signed [COORD_W-1:0] circ_cy;
	logic [COORD_W-2:0]        circ_r;

	result_t hit_queue[$];
	int      mismatches;
	int      burst_mode;

	ray_circle_intersection_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .ray(ray),
		.result_valid(result_valid), .result(result)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	function automatic result_t solve_hit(ray_t r);
		wide_t px, py, dx, dy, rr, a, h, c, disc, rad, root, cand, hs, num, q;
		logic  near_ok, far_ok;
		result_t res;
		res = '0;
		px = wide_t'(r.origin_x) - wide_t'(circ_cx);
		py = wide_t'(r.origin_y) - wide_t'(circ_cy);
		dx = wide_t'(r.dir_x);
		dy = wide_t'(r.dir_y);
		rr = wide_t'({1'b0, circ_r});
		a = dx * dx + dy * dy;
		h = dx * px + dy * py;
		c = px * px + py * py - rr * rr;
		disc = h * h - a * c;
		if (a == 0 || disc < 0) return res;
		near_ok = (h < 0) && (c > 0);
		far_ok = !near_ok && ((h < 0) || (c < 0));
		if (!near_ok && !far_ok) return res;
		rad = disc <<< (2 * FRAC_W);
		root = 0;
		for (int k = 110; k >= 0; k--) begin
			cand = root | (wide_t'(1) <<< k);
			if (cand * cand <= rad) root = cand;
		end
		hs = (h < 0 ? -h : h) <<< FRAC_W;
		if (near_ok) num = (hs > root) ? hs - root : 0;
		else if (h < 0) num = hs + root;
		else num = (root > hs) ? root - hs : 0;
		q = num / a;
		res.hit = 1'b1;
		res.far_root = far_ok;
		if (q > wide_t'(64'hFFFF_FFFF)) begin
			res.distance = '1;
			res.saturated = 1'b1;
		end else begin
			res.distance = q[COORD_W-1:0];
		end
		return res;
	endfunction

	always @(posedge clk) begin
		if (result_valid) begin
			if (hit_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", result);
			end else begin
				result_t exp_r;
				exp_r = hit_queue.pop_front();
				if (result.hit !== exp_r.hit || result.distance !== exp_r.distance ||
				    result.far_root !== exp_r.far_root ||
				    result.saturated !== exp_r.saturated) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected hit %b dist %h far %b sat %b, ",
							"got hit %b dist %h far %b sat %b"},
							exp_r.hit, exp_r.distance, exp_r.far_root, exp_r.saturated,
							result.hit, result.distance, result.far_root, result.saturated);
				end
			end
		end
	end

	// each transaction drops psel and penable and waits in the idle state before the task returns
	task automatic reg_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_CENTER_X: circ_cx = data;
			REG_CENTER_Y: circ_cy = data;
			REG_RADIUS:   circ_r = data[COORD_W-2:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_circle(logic [31:0] cx, logic [31:0] cy, logic [31:0] r);
		reg_write(REG_CENTER_X, cx);
		reg_write(REG_CENTER_Y, cy);
		reg_write(REG_RADIUS, r);
	endtask

	// without a gap, start stays high into the next transaction
	task automatic send_ray(ray_t r);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		ray <= r;
		do @(posedge clk); while (busy);
		hit_queue.push_back(solve_hit(r));
	endtask

	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		wait (hit_queue.size() == 0);
		repeat (10) @(posedge clk);
	endtask

	function automatic ray_t mk_ray(logic [31:0] ox, logic [31:0] oy,
		logic [31:0] dx, logic [31:0] dy);
		ray_t r;
		r.origin_x = ox;
		r.origin_y = oy;
		r.dir_x = dx;
		r.dir_y = dy;
		return r;
	endfunction

	// mostly small coordinates around the origin so hits are common
	function automatic logic [31:0] rand_coord(int span_bits);
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) return $urandom;
		if (sel == 1) return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
		return 32'($signed($urandom_range(0, (1 << (span_bits + 1)) - 1)) -
			(1 << span_bits));
	endfunction

	task automatic test_directed;
		// unit circle at the origin
		set_circle(32'h0, 32'h0, 32'h0001_0000);
		send_ray(mk_ray(32'hFFFE_0000, 32'h0, 32'h0001_0000, 32'h0));  // near hit
		send_ray(mk_ray(32'h0, 32'h0, 32'h0001_0000, 32'h0));          // inside, far root
		send_ray(mk_ray(32'hFFFE_0000, 32'h0001_0000, 32'h0001_0000, 32'h0)); // tangent
		send_ray(mk_ray(32'h0002_0000, 32'h0, 32'h0001_0000, 32'h0));  // behind
		send_ray(mk_ray(32'hFFFE_0000, 32'h0, 32'h0, 32'h0));          // zero direction
		send_ray(mk_ray(32'hFFFE_0000, 32'h0005_0000, 32'h0001_0000, 32'h0)); // disc < 0
		send_ray(mk_ray(32'h8000_0000, 32'h0, 32'h0000_0001, 32'h0));  // saturates
		send_ray(mk_ray(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_ray(mk_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
		send_ray(mk_ray(32'h0001_0000, 32'h0, 32'hFFFF_0000, 32'h0));  // on the circle
		send_ray(mk_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		drain();
		// extreme center and radius, top radius bit written but ignored
		set_circle(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_ray(mk_ray(32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF));
		send_ray(mk_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF));
		send_ray(mk_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0001_0000));
		drain();
		set_circle(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
		send_ray(mk_ray(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000));
		send_ray(mk_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0));
		drain();
	endtask

	task automatic test_random(int n_rays, int span_bits);
		ray_t r;
		for (int i = 0; i < n_rays; i++) begin
			if (i % 50 == 0) burst_mode = ($urandom_range(0, 2) == 0);
			r = mk_ray(rand_coord(span_bits), rand_coord(span_bits),
				rand_coord(span_bits - 2), rand_coord(span_bits - 2));
			if ($urandom_range(0, 15) == 0) r.dir_x = $urandom_range(0, 3);
			send_ray(r);
		end
		burst_mode = 0;
		drain();
	endtask

	task automatic test_random_circles;
		logic [31:0] rad;
		for (int p = 0; p < 6; p++) begin
			rad = (p == 5) ? 32'h7FFF_FFFF : 32'($urandom_range(0, 1 << 20));
			set_circle(32'($signed($urandom_range(0, 1 << 19)) - (1 << 18)),
				32'($signed($urandom_range(0, 1 << 19)) - (1 << 18)), rad);
			test_random(300, (p == 5) ? 30 : 20);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		ray = '0;
		circ_cx = '0;
		circ_cy = '0;
		circ_r = '0;
		mismatches = 0;
		burst_mode = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_circles();
		if (mismatches == 0 && hit_queue.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#50_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
design/rci_pkg.sv
design/rci_mul.sv
design/rci_sqrt.sv
design/rci_div.sv
design/ray_circle_intersection_unit.sv
sim/tb_top.sv
